[sv/fasm_pkg.sv]
// ----------------------------------------------------------------------------
// fasm_pkg
// shared types and constants of the float add/sub/mul unit
// ----------------------------------------------------------------------------
`default_nettype none

package fasm_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
  localparam logic [31:0] HIDDEN_ONE = 32'h4000_0000;
  localparam logic [31:0] FRAC_FIELD = 32'h3FFF_FF80;
  localparam logic [9:0]  EXP_BIAS   = 10'd127;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new request
    logic compute;  // add/sub or multiply step
    logic norm;     // one normalize shift step
  } dp_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic norm_done;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/fasm_datapath.sv]
// ----------------------------------------------------------------------------
// fasm_datapath
// unpack, align, add or multiply, then normalize by steps and pack
// ----------------------------------------------------------------------------
`default_nettype none

module fasm_datapath (
  input  wire logic             clk,
  input  wire fasm_pkg::dp_cmd_t cmd,
  output fasm_pkg::dp_sts_t      sts,
  input  wire logic [1:0]       in_action,
  input  wire logic [31:0]      in_operand_a,
  input  wire logic [31:0]      in_operand_b,
  output logic [31:0]           result_bits
);
  import fasm_pkg::*;

  logic [1:0]  act_r;
  logic [31:0] a_r, b_r;
  logic [31:0] mag_r, mag_nxt;
  logic [9:0]  exp_r, exp_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;

  logic [31:0] fa, fb, fa_s, fb_s, r, ma, mb;
  logic [9:0]  ea, eb, diff, e;
  logic [63:0] prod;
  logic [31:0] prod_hi;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [9:0] n);
    logic [4:0] s;
    s = (n > 10'd31) ? 5'd31 : n[4:0];
    return $unsigned($signed(v) >>> s);
  endfunction

  always_comb begin
    if (a_r[30:0] == 31'd0) begin
      fa = '0; ea = '0;
    end else begin
      ea = {2'b00, a_r[30:23]} - EXP_BIAS;
      fa = ({a_r[24:0], 7'd0} & FRAC_FIELD) | HIDDEN_ONE;
      if (a_r[31]) fa = 32'd0 - fa;
    end
    if (b_r[30:0] == 31'd0) begin
      fb = '0; eb = '0;
    end else begin
      eb = {2'b00, b_r[30:23]} - EXP_BIAS;
      fb = ({b_r[24:0], 7'd0} & FRAC_FIELD) | HIDDEN_ONE;
      if (b_r[31]) fb = 32'd0 - fb;
    end
    diff = ea - eb;
    fa_s = fa; fb_s = fb; e = ea;
    if (!diff[9] && diff != 10'd0) begin
      fb_s = asr(fb, diff);
    end else if (diff[9]) begin
      fa_s = asr(fa, 10'd0 - diff);
      e = eb;
    end
    if (act_r == ACT_SUB) r = asr(fa_s, 10'd1) - asr(fb_s, 10'd1);
    else                  r = asr(fa_s, 10'd1) + asr(fb_s, 10'd1);
    ma = fa[31] ? 32'd0 - fa : fa;
    mb = fb[31] ? 32'd0 - fb : fb;
    prod = {ma[30:0], 1'b0} * {mb[30:0], 1'b0};
    prod_hi = prod[63:32];
  end

  always_comb begin
    mag_nxt = mag_r; exp_nxt = exp_r; neg_nxt = neg_r; zero_nxt = zero_r;
    if (cmd.compute) begin
      unique case (act_r)
        ACT_ADD, ACT_SUB: begin
          neg_nxt = r[31];
          mag_nxt = r[31] ? 32'd0 - r : r;
          exp_nxt = e + 10'd1;
        end
        ACT_MUL: begin
          neg_nxt = a_r[31] ^ b_r[31];
          mag_nxt = prod_hi;
          exp_nxt = ea + eb;
        end
        default: begin
          neg_nxt = 1'b0; mag_nxt = '0; exp_nxt = '0;
        end
      endcase
      zero_nxt = (mag_nxt == 32'd0);
      if (mag_nxt[31]) begin
        mag_nxt = mag_nxt >> 1;
        exp_nxt = exp_nxt + 10'd1;
      end
    end else if (cmd.norm && !zero_r && !mag_r[30]) begin
      mag_nxt = mag_r << 1;
      exp_nxt = exp_r - 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      a_r   <= in_operand_a;
      b_r   <= in_operand_b;
    end
    mag_r  <= mag_nxt;
    exp_r  <= exp_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  logic [9:0] bexp;
  assign bexp = exp_r + EXP_BIAS;
  assign sts.norm_done = zero_r || mag_r[30];
  assign result_bits = zero_r ? 32'd0 : {neg_r, bexp[7:0], mag_r[29:7]};

endmodule

`default_nettype wire

[sv/fasm_ctrl.sv]
// ----------------------------------------------------------------------------
// fasm_ctrl
// sequencer: load, compute, normalize steps, output register handshake
// ----------------------------------------------------------------------------
`default_nettype none

module fasm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic [31:0]       result_bits,
  output logic [31:0]            out_result_bits,
  output fasm_pkg::dp_cmd_t      cmd,
  input  wire fasm_pkg::dp_sts_t sts
);
  import fasm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_NORM} state_t;
  state_t state_r;
  logic   out_valid_r, out_valid_nxt;
  logic [31:0] out_r;

  // accept while the finished result still waits in the output register
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_bits = out_r;
  assign cmd.load = in_valid && in_ready;
  assign cmd.compute = (state_r == S_COMP);
  assign cmd.norm = (state_r == S_NORM);

  logic finish;
  assign finish = (state_r == S_NORM) && sts.norm_done && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: if (cmd.load) state_r <= S_COMP;
        S_COMP: state_r <= S_NORM;
        S_NORM: begin
          if (finish) begin
            state_r <= S_IDLE;
            out_r <= result_bits;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result dropped while stalled");
  a_norm_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMP |=> state_r == S_NORM)
    else $error("compute not followed by normalize");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("finished result not presented");

endmodule

`default_nettype wire

[sv/float_add_sub_mul_unit.sv]
// ----------------------------------------------------------------------------
// float_add_sub_mul_unit
// single-precision add, subtract, multiply with truncation
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid in_ready in_action in_operand_a in_operand_b
// out      output     out_valid out_ready out_result_bits
//
// a request goes through load, a compute step (align+add or
// 32x32 multiply), then one normalize shift per cycle until the hidden one
// reaches bit 30. one request in flight; the next is taken once the
// result sits in the output register. reset is synchronous and clears
// control only. out stalls hold the result; finishing waits for space.
`default_nettype none

module float_add_sub_mul_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_result_bits
);
  import fasm_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] result_bits;

  fasm_datapath u_dp (
    .clk, .cmd, .sts, .in_action, .in_operand_a, .in_operand_b, .result_bits
  );

  fasm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .result_bits, .out_result_bits, .cmd, .sts
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives add, subtract, multiply and the unused action into the float unit
// with random idling on both sides, predicts each truncated result and
// compares it with what comes out, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import fasm_pkg::*;

  localparam int N_RAND = 1130;
  localparam int WDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_ADD;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_bits;

  int  n_errors = 0;
  bit  calm = 1'b0;
  bit  stim_done = 1'b0;
  int  idle_cycles = 0;

  always #4 clk = ~clk;

  float_add_sub_mul_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_bits(out_result_bits)
  );

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    n_errors++;
  endtask

  // arithmetic right shift, saturating at 31
  function automatic logic [31:0] sra_sat(input logic [31:0] v, input int n);
    if (n > 31) n = 31;
    return $signed(v) >>> n;
  endfunction

  function automatic void split_float(input logic [31:0] bits, output logic [31:0] frac,
                                      output int ex);
    if (bits[30:0] == '0) begin
      frac = '0;
      ex = 0;
    end else begin
      ex = int'(bits[30:23]) - 127;
      frac = {2'b01, bits[22:0], 7'b0};
      if (bits[31]) frac = -frac;
    end
  endfunction

  function automatic logic [31:0] norm_pack(input bit neg, input logic [31:0] mag,
                                            input int ex);
    int e;
    logic [31:0] m;
    logic [7:0] bexp;
    m = mag;
    e = ex;
    if (m == '0) return '0;
    if (m[31]) begin
      m = m >> 1;
      e++;
    end
    while (!m[30]) begin
      m = m << 1;
      e--;
    end
    bexp = 8'(e + 127);
    return {neg, bexp, m[29:7]};
  endfunction

  function automatic logic [31:0] float_result(input logic [1:0] act,
                                               input logic [31:0] a, input logic [31:0] b);
    logic [31:0] fa, fb, r;
    logic [63:0] prod;
    int ea, eb, e, d;
    split_float(a, fa, ea);
    split_float(b, fb, eb);
    case (act)
      ACT_ADD, ACT_SUB: begin
        d = ea - eb;
        e = ea;
        if (d > 0) fb = sra_sat(fb, d);
        else if (d < 0) begin
          fa = sra_sat(fa, -d);
          e = eb;
        end
        r = (act == ACT_SUB) ? sra_sat(fa, 1) - sra_sat(fb, 1)
                             : sra_sat(fa, 1) + sra_sat(fb, 1);
        if (r[31]) return norm_pack(1'b1, -r, e + 1);
        return norm_pack(1'b0, r, e + 1);
      end
      ACT_MUL: begin
        if (fa[31]) fa = -fa;
        if (fb[31]) fb = -fb;
        prod = {32'b0, fa << 1} * {32'b0, fb << 1};
        return norm_pack(a[31] ^ b[31], prod[63:32], ea + eb);
      end
      default: return '0;
    endcase
  endfunction

  class result_board;
    logic [31:0] pending[$];
    logic [31:0] req_a[$];
    logic [31:0] req_b[$];
    logic [1:0]  req_act[$];

    function void note_request(logic [1:0] act, logic [31:0] a, logic [31:0] b);
      pending.push_back(float_result(act, a, b));
      req_act.push_back(act);
      req_a.push_back(a);
      req_b.push_back(b);
    endfunction

    task check_result(logic [31:0] got);
      logic [31:0] want, a, b;
      logic [1:0] act;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      act = req_act.pop_front();
      a = req_a.pop_front();
      b = req_b.pop_front();
      if (got !== want)
        report($sformatf("act %0d a %h b %h: result_bits %h, want %h", act, a, b, got, want));
    endtask
  endclass

  result_board board = new();

  // sample at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_request(in_action, in_operand_a, in_operand_b);
      if (out_valid && out_ready) board.check_result(out_result_bits);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // receiver stalls
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic send_request(input logic [1:0] act, input logic [31:0] a,
                              input logic [31:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 7))
      0: v[30:0] = '0;                                  // signed zero
      1: v[30:23] = 8'(127 + $urandom_range(0, 8) - 4); // near one
      2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] near_float(input logic [31:0] x);
    logic [31:0] v;
    v = x;
    v[30:23] = 8'(int'(x[30:23]) + $urandom_range(0, 6) - 3);
    if ($urandom_range(0, 1)) v[22:0] = 23'($urandom());
    if ($urandom_range(0, 3) == 0) v[31] = ~v[31];
    return v;
  endfunction

  initial begin
    logic [31:0] a, b;
    logic [1:0] act;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    for (int k = 0; k < 4; k++) begin
      act = 2'(k);
      send_request(act, 32'h3F80_0000, 32'h3F80_0000);
      send_request(act, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    end
    send_request(ACT_SUB, 32'h4040_0000, 32'h4040_0000); // exact cancel gives +0
    send_request(ACT_ADD, 32'h8000_0000, 32'h8000_0000); // both negative zero
    send_request(ACT_ADD, 32'h3E00_0000, 32'h0000_0000); // zero with negative exponent
    send_request(ACT_ADD, 32'h7F00_0000, 32'h0080_0000); // shift far past 31
    send_request(ACT_ADD, 32'h7F00_0000, 32'h8080_0000); // leaves sign copies
    send_request(ACT_MUL, 32'h3FFF_FFFF, 32'hBFFF_FFFF); // product two or more
    send_request(ACT_MUL, 32'h7F80_0000, 32'h7F80_0000); // exponent wraps
    send_request(ACT_MUL, 32'h0080_0000, 32'h0080_0000);
    send_request(ACT_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_request(ACT_SUB, 32'h3F80_0001, 32'h3F80_0000);
    send_request(ACT_MUL, 32'h0000_0000, 32'hC2F6_E979);
    send_request(ACT_NONE, 32'h0000_0000, 32'h0000_0000);

    for (int i = 0; i < N_RAND; i++) begin
      if (i > N_RAND - 150) calm = 1'b1;
      act = ($urandom_range(0, 15) == 0) ? ACT_NONE : 2'($urandom_range(0, 2));
      a = rand_float();
      b = ($urandom_range(0, 2) == 0) ? near_float(a) : rand_float();
      send_request(act, a, b);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    wait (rst_n);
    wait (idle_cycles >= WDOG_LIMIT);
    $display("timeout with nothing accepted");
    $display("tb: FAIL");
    $finish;
  end
endmodule
